// File: rtl/ordered_list_positional_engine_unit_macros.svh
// Assertion macros for the ordered list engine
`ifndef ORDERED_LIST_POSITIONAL_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_POSITIONAL_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OLPE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olpe: same-cycle check failed");
`define OLPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olpe: next-cycle check failed");
`else
`define OLPE_ASSERT_SAME(label, clk, rst, ante, cons)
`define OLPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/olpe_pkg.sv
// Shared types and constants of the ordered list engine
`timescale 1ns / 1ps
package olpe_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int MODE_W       = 3;
   localparam int POS_W        = 6;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 6;

   localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_LAST  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd6;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } olpe_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        entry_count;
      logic signed [VALUE_W-1:0] entry_value;
      logic                      last;
   } olpe_rsp_type;

   typedef struct packed {
      logic n_we;
      logic p_we;
      logic v_we;
   } olpe_ram_we_type;

   typedef struct packed {
      logic pop;
      logic push;
   } olpe_fs_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_INS_B,
      ST_INS2,
      ST_DEL,
      ST_DUMPA,
      ST_DUMP
   } olpe_state_type;

endpackage

// File: rtl/olpe_slot_ram.sv
// Single write port, single registered read port slot memory
`timescale 1ns / 1ps
module olpe_slot_ram import olpe_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = VALUE_W
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/olpe_free_stack.sv
// Free-slot stack with low-water mark standing in for the reset fill
`timescale 1ns / 1ps
module olpe_free_stack import olpe_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  olpe_fs_ctl_type             fs_ctl,
   input  logic [$clog2(CAPACITY)-1:0] push_slot,
   output logic [$clog2(CAPACITY)-1:0] new_slot
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]  top_ff, top_in;
   logic [CNT_W-1:0]  lw_ff, lw_in;
   logic [CNT_W-1:0]  top_dec;
   logic [SLOT_W-1:0] pop_idx, push_idx;
   logic [SLOT_W-1:0] stack_ff [CAPACITY];
   logic [SLOT_W-1:0] rd_ff;
   logic [SLOT_W-1:0] fresh_idx_ff;
   logic              fresh_ff;
   logic              untouched;

   assign top_dec   = top_ff - 1'b1;
   assign pop_idx   = top_dec[SLOT_W-1:0];
   assign push_idx  = top_ff[SLOT_W-1:0];
   // entries below the low-water mark were never written and still hold their own index
   assign untouched = (top_ff <= lw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= CNT_W'(CAPACITY);
         lw_ff  <= CNT_W'(CAPACITY);
      end else begin
         top_ff <= top_in;
         lw_ff  <= lw_in;
      end
   end

   always_comb begin
      top_in = top_ff;
      lw_in  = lw_ff;
      if (fs_ctl.pop) begin
         top_in = top_dec;
         if (untouched) begin
            lw_in = top_dec;
         end
      end else if (fs_ctl.push) begin
         top_in = top_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fs_ctl.push) begin
         stack_ff[push_idx] <= push_slot;
      end
      if (fs_ctl.pop) begin
         rd_ff        <= stack_ff[pop_idx];
         fresh_ff     <= untouched;
         fresh_idx_ff <= pop_idx;
      end
   end

   assign new_slot = fresh_ff ? fresh_idx_ff : rd_ff;

endmodule

// File: rtl/olpe_ctrl.sv
// Sequencer: checks, link walk, relink steps and result generation
`timescale 1ns / 1ps
module olpe_ctrl import olpe_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  olpe_req_type                req_data,
   output logic                        rsp_strobe,
   output olpe_rsp_type                rsp_data,
   output logic [$clog2(CAPACITY)-1:0] rd_addr,
   input  logic [$clog2(CAPACITY)-1:0] n_rdata,
   input  logic [$clog2(CAPACITY)-1:0] p_rdata,
   input  logic [VALUE_W-1:0]          v_rdata,
   output olpe_ram_we_type             ram_we,
   output logic [$clog2(CAPACITY)-1:0] n_waddr,
   output logic [$clog2(CAPACITY)-1:0] n_wdata,
   output logic [$clog2(CAPACITY)-1:0] p_waddr,
   output logic [$clog2(CAPACITY)-1:0] p_wdata,
   output logic [$clog2(CAPACITY)-1:0] v_waddr,
   output logic [VALUE_W-1:0]          v_wdata,
   output olpe_fs_ctl_type             fs_ctl,
   output logic [$clog2(CAPACITY)-1:0] push_slot,
   input  logic [$clog2(CAPACITY)-1:0] new_slot
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   olpe_state_type    state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [SLOT_W-1:0] steps_ff, steps_in;
   logic [SLOT_W-1:0] a_ff, a_in;
   logic [SLOT_W-1:0] b_ff, b_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  kidx_ff, kidx_in;
   logic              walk_ins_ff, walk_ins_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   olpe_rsp_type      rsp_ff, rsp_in;

   logic [CMP_W-1:0]  pos_x, cnt_x;
   logic              full, empty, accept, dump_last;

   assign pos_x     = CMP_W'(req_data.position);
   assign cnt_x     = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign accept    = start && (state_ff == ST_IDLE);
   assign dump_last = (kidx_ff == count_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      val_ff      <= val_in;
      steps_ff    <= steps_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      kidx_ff     <= kidx_in;
      walk_ins_ff <= walk_ins_in;
      rsp_ff      <= rsp_in;
   end

   // one shared read address for the next, prev and value memories
   assign rd_addr = (state_ff == ST_IDLE) ? tail_ff : n_rdata;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      val_in        = val_ff;
      steps_in      = steps_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      kidx_in       = kidx_ff;
      walk_ins_in   = walk_ins_ff;
      rsp_strobe_in = 1'b0;
      rsp_in.status      = STAT_OK;
      rsp_in.entry_value = '0;
      rsp_in.last        = 1'b1;
      ram_we        = '0;
      n_waddr       = new_slot;
      n_wdata       = n_rdata;
      p_waddr       = new_slot;
      p_wdata       = a_ff;
      v_waddr       = new_slot;
      v_wdata       = val_ff;
      fs_ctl        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in     = req_data.mode;
               val_in      = req_data.value;
               a_in        = tail_ff;
               walk_ins_in = 1'b0;
               steps_in    = SLOT_W'(req_data.position - 1'b1);
               kidx_in     = '0;
               unique case (req_data.mode)
                  MODE_INS_FRONT, MODE_INS_END: begin
                     if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_FULL;
                     end else begin
                        fs_ctl.pop = 1'b1;
                        state_in   = ST_INS_B;
                     end
                  end
                  MODE_INS_POS: begin
                     if (pos_x > cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_RANGE;
                     end else if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_FULL;
                     end else if (pos_x == '0 || empty) begin
                        fs_ctl.pop = 1'b1;
                        state_in   = ST_INS_B;
                     end else begin
                        fs_ctl.pop  = 1'b1;
                        walk_ins_in = 1'b1;
                        state_in    = ST_WALK;
                     end
                  end
                  MODE_DEL_FIRST: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        steps_in = '0;
                        state_in = ST_WALK;
                     end
                  end
                  MODE_DEL_LAST: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        state_in = ST_DEL;
                     end
                  end
                  MODE_DEL_POS: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else if (pos_x == '0 || pos_x > cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_RANGE;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  MODE_DUMP: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        state_in = ST_DUMPA;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // read data holds the current slot; the same read fetches its links
            if (steps_ff == '0) begin
               a_in     = n_rdata;
               state_in = walk_ins_ff ? ST_INS_B : ST_DEL;
            end else begin
               steps_in = steps_ff - 1'b1;
            end
         end
         ST_INS_B: begin
            ram_we.n_we = 1'b1;
            ram_we.p_we = 1'b1;
            ram_we.v_we = 1'b1;
            b_in        = n_rdata;
            if (empty) begin
               n_wdata       = new_slot;
               p_wdata       = new_slot;
               tail_in       = new_slot;
               count_in      = count_ff + 1'b1;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_INS2;
            end
         end
         ST_INS2: begin
            ram_we.n_we = 1'b1;
            ram_we.p_we = 1'b1;
            n_waddr     = a_ff;
            n_wdata     = new_slot;
            p_waddr     = b_ff;
            p_wdata     = new_slot;
            if (mode_ff == MODE_INS_END || (walk_ins_ff && a_ff == tail_ff)) begin
               tail_in = new_slot;
            end
            count_in      = count_ff + 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_DEL: begin
            if (count_ff == CNT_W'(1)) begin
               tail_in = '0;
            end else begin
               ram_we.n_we = 1'b1;
               ram_we.p_we = 1'b1;
               n_waddr     = p_rdata;
               n_wdata     = n_rdata;
               p_waddr     = n_rdata;
               p_wdata     = p_rdata;
               if (a_ff == tail_ff) begin
                  tail_in = p_rdata;
               end
            end
            fs_ctl.push   = 1'b1;
            count_in      = count_ff - 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_DUMPA: begin
            state_in = ST_DUMP;
         end
         ST_DUMP: begin
            rsp_strobe_in      = 1'b1;
            rsp_in.entry_value = $signed(v_rdata);
            rsp_in.last        = dump_last;
            kidx_in            = kidx_ff + 1'b1;
            if (dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.entry_count = COUNT_W'(count_in);
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign push_slot  = a_ff;

endmodule

// File: rtl/ordered_list_positional_engine_unit.sv
// Top level of the ordered list engine: slot memories, free stack and sequencer
`timescale 1ns / 1ps
`include "ordered_list_positional_engine_unit_macros.svh"
// Circular doubly linked list of up to CAPACITY signed 32-bit entries. An item is
// taken when start is high and busy low; results appear one cycle each on rsp_data
// with rsp_strobe high and cannot be held off. An error or an unused mode is
// answered straight from idle; inserts at front or end and deletes of the last
// entry relink without a walk, while deletes of the first entry, inserts after a
// nonzero position and deletes at a position first walk the next links. A dump
// returns one entry per cycle. busy stays high until the final result is being
// registered. The link walk follows one next link per cycle through the single
// read port of the link memories.
module ordered_list_positional_engine_unit import olpe_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  olpe_req_type req_data,
   output logic         rsp_strobe,
   output olpe_rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(CAPACITY);

   logic [SLOT_W-1:0]  rd_addr;
   logic [SLOT_W-1:0]  n_rdata, p_rdata;
   logic [VALUE_W-1:0] v_rdata;
   olpe_ram_we_type    ram_we;
   logic [SLOT_W-1:0]  n_waddr, n_wdata, p_waddr, p_wdata, v_waddr;
   logic [VALUE_W-1:0] v_wdata;
   olpe_fs_ctl_type    fs_ctl;
   logic [SLOT_W-1:0]  push_slot, new_slot;

   olpe_slot_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_next_ram (
      .clock (clock),
      .we    (ram_we.n_we),
      .waddr (n_waddr),
      .wdata (n_wdata),
      .raddr (rd_addr),
      .rdata (n_rdata)
   );

   olpe_slot_ram #(.DEPTH(CAPACITY), .WIDTH(SLOT_W)) u_prev_ram (
      .clock (clock),
      .we    (ram_we.p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (rd_addr),
      .rdata (p_rdata)
   );

   olpe_slot_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_W)) u_value_ram (
      .clock (clock),
      .we    (ram_we.v_we),
      .waddr (v_waddr),
      .wdata (v_wdata),
      .raddr (rd_addr),
      .rdata (v_rdata)
   );

   olpe_free_stack #(.CAPACITY(CAPACITY)) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .fs_ctl    (fs_ctl),
      .push_slot (push_slot),
      .new_slot  (new_slot)
   );

   olpe_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .rd_addr    (rd_addr),
      .n_rdata    (n_rdata),
      .p_rdata    (p_rdata),
      .v_rdata    (v_rdata),
      .ram_we     (ram_we),
      .n_waddr    (n_waddr),
      .n_wdata    (n_wdata),
      .p_waddr    (p_waddr),
      .p_wdata    (p_wdata),
      .v_waddr    (v_waddr),
      .v_wdata    (v_wdata),
      .fs_ctl     (fs_ctl),
      .push_slot  (push_slot),
      .new_slot   (new_slot)
   );

   // an accepted item either answers at once or keeps the block busy
   `OLPE_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)
   // a dump streams without gaps until its last entry
   `OLPE_ASSERT_NEXT(a_dump_no_gap, clock, reset, rsp_strobe && !rsp_data.last, rsp_strobe)
   // while an item still owes results, no new item can be taken
   `OLPE_ASSERT_SAME(a_busy_mid_item, clock, reset, rsp_strobe && !rsp_data.last, busy)

endmodule

// File: test/tb_ordered_list_positional_engine_unit.sv
// Self-checking testbench for the ordered list engine, with a queue-based list predictor
`timescale 1ns / 1ps
module tb_ordered_list_positional_engine_unit import olpe_pkg::*; ;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam int                CYCLE_LIMIT = 100000;
   localparam int                ITEMS_PER_PHASE = 58;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   olpe_req_type req_data = '0;
   logic         rsp_strobe;
   olpe_rsp_type rsp_data;

   int unsigned cycle_count = 0;
   int          idle_pct = 11;
   bit          grow = 1'b1;

   class list_scoreboard;
      logic signed [VALUE_W-1:0] list_values[$];
      olpe_rsp_type              due_results[$];
      int                        errors = 0;

      function void add_result(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] v,
                               logic fin);
         olpe_rsp_type r;
         r.status      = st;
         r.entry_count = COUNT_W'(list_values.size());
         r.entry_value = v;
         r.last        = fin;
         due_results.push_back(r);
      endfunction

      // Apply one accepted item to the list and queue the results it causes
      function void note_input(olpe_req_type item);
         int                  n;
         logic [STATUS_W-1:0] st;
         n  = list_values.size();
         st = STAT_OK;
         case (item.mode)
            MODE_INS_FRONT: begin
               if (n >= CAPACITY_DEF) st = STAT_FULL;
               else list_values.push_front(item.value);
            end
            MODE_INS_END: begin
               if (n >= CAPACITY_DEF) st = STAT_FULL;
               else list_values.push_back(item.value);
            end
            MODE_INS_POS: begin
               // range is checked before fullness
               if (int'(item.position) > n) st = STAT_RANGE;
               else if (n >= CAPACITY_DEF) st = STAT_FULL;
               else list_values.insert(int'(item.position), item.value);
            end
            MODE_DEL_FIRST: begin
               if (n == 0) st = STAT_EMPTY;
               else void'(list_values.pop_front());
            end
            MODE_DEL_LAST: begin
               if (n == 0) st = STAT_EMPTY;
               else void'(list_values.pop_back());
            end
            MODE_DEL_POS: begin
               if (n == 0) st = STAT_EMPTY;
               else if (item.position == 0 || int'(item.position) > n) st = STAT_RANGE;
               else list_values.delete(int'(item.position) - 1);
            end
            MODE_DUMP: begin
               if (n == 0) st = STAT_EMPTY;
               else begin
                  foreach (list_values[i]) add_result(STAT_OK, list_values[i], i == n - 1);
                  return;
               end
            end
            default: ;
         endcase
         add_result(st, '0, 1'b1);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(olpe_rsp_type got);
         olpe_rsp_type want;
         if (due_results.size() == 0) begin
            $error("result with nothing outstanding: 0x%0h", got);
            errors++;
            return;
         end
         want = due_results.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
         compare_field("entry_value", want.entry_value, got.entry_value);
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   list_scoreboard list_check = new();

   ordered_list_positional_engine_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) list_check.check_result(rsp_data);
   end

   function automatic olpe_req_type make_item(logic [MODE_W-1:0] mode,
                                              logic [POS_W-1:0] position,
                                              logic signed [VALUE_W-1:0] value);
      olpe_req_type item;
      item.mode     = mode;
      item.position = position;
      item.value    = value;
      return item;
   endfunction

   // Biased walk between empty and full: grow until full, then shrink until empty
   function automatic olpe_req_type random_item();
      olpe_req_type item;
      int           n;
      int           roll;
      int           pick;
      bit           ins;
      n = list_check.list_values.size();
      if (n >= CAPACITY_DEF && $urandom_range(3) == 0) grow = 1'b0;
      if (n == 0 && $urandom_range(2) == 0) grow = 1'b1;
      roll = $urandom_range(99);
      pick = $urandom_range(2);
      if (roll < 5) item.mode = MODE_DUMP;
      else if (roll < 7) item.mode = MODE_UNUSED;
      else begin
         ins = grow ? ($urandom_range(99) < 88) : ($urandom_range(99) < 12);
         if (ins) item.mode = (pick == 0) ? MODE_INS_FRONT :
                              (pick == 1) ? MODE_INS_END : MODE_INS_POS;
         else item.mode = (pick == 0) ? MODE_DEL_FIRST :
                          (pick == 1) ? MODE_DEL_LAST : MODE_DEL_POS;
      end
      roll = $urandom_range(99);
      if (roll < 10) item.position = POS_W'($urandom_range(63));
      else if (roll < 25) item.position = POS_W'(n);
      else if (item.mode == MODE_DEL_POS && n > 0) item.position = POS_W'($urandom_range(n, 1));
      else item.position = POS_W'($urandom_range(n));
      case ($urandom_range(19))
         0: item.value = 32'sh8000_0000;
         1: item.value = 32'sh7FFF_FFFF;
         2: item.value = -32'sd1;
         3: item.value = '0;
         default: item.value = $urandom();
      endcase
      return item;
   endfunction

   // Present one item, with a random gap first, and hold it until taken
   task automatic issue(input olpe_req_type item);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      list_check.note_input(item);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (list_check.due_results.size() != 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list cases
      issue(make_item(MODE_DUMP, 0, 0));
      issue(make_item(MODE_DEL_FIRST, 0, 0));
      issue(make_item(MODE_DEL_LAST, 0, 0));
      issue(make_item(MODE_DEL_POS, 0, 0));
      issue(make_item(MODE_INS_POS, 1, 0));
      issue(make_item(MODE_UNUSED, 6'h3F, -32'sd1));
      // insert at position zero on empty, then the extremes of value
      issue(make_item(MODE_INS_POS, 0, 5));
      issue(make_item(MODE_INS_FRONT, 0, 32'sh8000_0000));
      issue(make_item(MODE_INS_END, 6'h3F, 32'sh7FFF_FFFF));
      issue(make_item(MODE_INS_POS, 3, -32'sd1));
      issue(make_item(MODE_INS_POS, 1, 0));
      issue(make_item(MODE_INS_POS, 0, 32'sh5555_5555));
      issue(make_item(MODE_DUMP, 0, 0));
      issue(make_item(MODE_DEL_POS, 0, 0));
      issue(make_item(MODE_DEL_POS, 6'h3F, 0));
      issue(make_item(MODE_INS_POS, 6'h3F, 0));
      issue(make_item(MODE_DEL_POS, 6, 0));
      issue(make_item(MODE_DEL_POS, 1, 0));
      issue(make_item(MODE_DEL_POS, 2, 0));
      issue(make_item(MODE_DEL_FIRST, 0, 0));
      issue(make_item(MODE_DUMP, 0, 0));
      issue(make_item(MODE_DEL_LAST, 0, 0));
      issue(make_item(MODE_DUMP, 0, 0));
      // append to a one-entry list, then delete its first entry
      issue(make_item(MODE_INS_END, 0, 32'sh2AAA_AAAA));
      issue(make_item(MODE_DEL_FIRST, 0, 0));
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 11 : (phase == 1) ? 81 : 0;
         repeat (ITEMS_PER_PHASE) issue(random_item());
         wait_drained();
      end

      repeat (CAPACITY_DEF + 4) @(posedge clock);
      if (list_check.due_results.size() != 0) begin
         $error("%0d results never arrived", list_check.due_results.size());
         list_check.errors++;
      end
      if (list_check.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/olpe_pkg.sv
rtl/olpe_slot_ram.sv
rtl/olpe_free_stack.sv
rtl/olpe_ctrl.sv
rtl/ordered_list_positional_engine_unit.sv
test/tb_ordered_list_positional_engine_unit.sv
